[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/sh24_pkg.sv]
`timescale 1ns / 1ps

package sh24_pkg;

    localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_C3 = 64'h7465646279746573;

    localparam logic [63:0] FINAL_XOR = 64'h00000000000000ff;
    localparam int          LEN_SHIFT = 56;
    localparam logic [3:0]  FULL_WORD_BYTES = 4'd8;
    localparam logic [7:0]  FULL_WORD_LEN = 8'd8;

    localparam int          QUEUE_DEPTH = 2;

    localparam int          CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_HIGH = 2'd1;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } lanes_t;

    // one unit of work for the back end: a block to absorb
    typedef struct packed {
        logic        start;
        logic        fin;
        logic [63:0] word;
        logic [63:0] key_low;
        logic [63:0] key_high;
    } op_t;

    typedef struct packed {
        logic pend;
        logic in_msg;
    } front_status_t;

    function automatic logic [63:0] rotl64(logic [63:0] x, int unsigned s);
        return (x << s) | (x >> (64 - s));
    endfunction

    function automatic lanes_t sip_round(lanes_t v);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
        a = v.a;
        b = v.b;
        c = v.c;
        d = v.d;
        a = a + b; b = rotl64(b, 13); b = b ^ a; a = rotl64(a, 32);
        c = c + d; d = rotl64(d, 16); d = d ^ c;
        a = a + d; d = rotl64(d, 21); d = d ^ a;
        c = c + b; b = rotl64(b, 17); b = b ^ c; c = rotl64(c, 32);
        return '{a: a, b: b, c: c, d: d};
    endfunction

    function automatic lanes_t sip_init(logic [63:0] k0, logic [63:0] k1);
        return '{a: SIP_C0 ^ k0, b: SIP_C1 ^ k1, c: SIP_C2 ^ k0, d: SIP_C3 ^ k1};
    endfunction

    function automatic lanes_t sip_absorb(lanes_t v, logic [63:0] m);
        lanes_t t;
        t   = v;
        t.d = t.d ^ m;
        t   = sip_round(sip_round(t));
        t.a = t.a ^ m;
        return t;
    endfunction

endpackage

[sv/sh24_front.sv]
`timescale 1ns / 1ps

module sh24_front
    import sh24_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [63:0]            message_word,
    input  logic [3:0]             byte_count,
    input  logic                   last,
    output logic                   push,
    output op_t                    push_op,
    input  logic                   q_full,
    output front_status_t          status
);

    logic [63:0] key_low_reg;
    logic [63:0] key_high_reg;
    logic [7:0]  len_reg;
    logic [7:0]  len_next;
    logic        in_msg_reg;
    logic        in_msg_next;
    logic        pend_reg;
    logic        pend_next;
    logic [63:0] pend_word_reg;
    logic [63:0] pend_word_next;

    logic        accept;
    logic [3:0]  cnt_sat;
    logic        full_last;
    logic [7:0]  len_base;
    logic [7:0]  len_tail;
    logic [7:0]  len_word;
    logic [63:0] byte_mask;
    logic [63:0] tail_block;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full && !pend_reg;
    assign accept    = in_valid && in_ready;

    assign cnt_sat   = (byte_count > FULL_WORD_BYTES) ? FULL_WORD_BYTES : byte_count;
    assign full_last = last && (cnt_sat == FULL_WORD_BYTES);
    assign len_base  = in_msg_reg ? len_reg : 8'd0;
    assign len_tail  = len_base + {4'd0, cnt_sat};
    assign len_word  = len_base + FULL_WORD_LEN;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            byte_mask[i*8 +: 8] = (4'(i) < cnt_sat) ? 8'hff : 8'h00;
        end
    end

    assign tail_block = (message_word & byte_mask) | ({56'd0, len_tail} << LEN_SHIFT);

    always_comb
    begin
        push_op.key_low  = key_low_reg;
        push_op.key_high = key_high_reg;
        if (pend_reg)
        begin
            // length-only block behind a full last word
            push          = !q_full;
            push_op.start = 1'b0;
            push_op.fin   = 1'b1;
            push_op.word  = pend_word_reg;
        end
        else
        begin
            push          = accept;
            push_op.start = !in_msg_reg;
            push_op.fin   = last && !full_last;
            push_op.word  = (!last || full_last) ? message_word : tail_block;
        end
    end

    always_comb
    begin
        len_next       = len_reg;
        in_msg_next    = in_msg_reg;
        pend_next      = pend_reg;
        pend_word_next = pend_word_reg;
        if (pend_reg && !q_full)
        begin
            pend_next = 1'b0;
        end
        if (accept)
        begin
            in_msg_next    = !last;
            len_next       = (last && !full_last) ? len_tail : len_word;
            pend_next      = full_last;
            pend_word_next = {56'd0, len_word} << LEN_SHIFT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            len_reg      <= '0;
            in_msg_reg   <= 1'b0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                    CFG_KEY_HIGH: key_high_reg <= cfg_data;
                    default:      ;
                endcase
            end
            len_reg    <= len_next;
            in_msg_reg <= in_msg_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_word_reg <= pend_word_next;
    end

    assign status.pend   = pend_reg;
    assign status.in_msg = in_msg_reg;

endmodule

[sv/sh24_queue.sv]
`timescale 1ns / 1ps

module sh24_queue
    import sh24_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    input  logic pop,
    output op_t  head,
    output logic empty,
    output logic full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    op_t              mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign head  = mem[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_op;
        end
    end

endmodule

[sv/sh24_back.sv]
`timescale 1ns / 1ps

module sh24_back
    import sh24_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  op_t         head,
    input  logic        q_empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest
);

    lanes_t      lanes_reg;
    lanes_t      base;
    lanes_t      absorbed;
    lanes_t      s1_reg;
    lanes_t      s2_reg;
    logic        s1_valid_reg;
    logic        s2_valid_reg;
    logic        out_valid_reg;
    logic [63:0] digest_reg;

    logic        out_free;
    logic        s2_ready;
    logic        s1_ready;
    lanes_t      closed;
    lanes_t      s2_calc;
    lanes_t      out_calc;

    assign base     = head.start ? sip_init(head.key_low, head.key_high) : lanes_reg;
    assign absorbed = sip_absorb(base, head.word);

    assign out_free = !out_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || out_free;
    assign s1_ready = !s1_valid_reg || s2_ready;

    // a closing block needs room in the finalization pipe
    assign pop = !q_empty && (!head.fin || s1_ready);

    assign closed   = '{a: absorbed.a, b: absorbed.b, c: absorbed.c ^ FINAL_XOR, d: absorbed.d};
    assign s2_calc  = sip_round(sip_round(s1_reg));
    assign out_calc = sip_round(sip_round(s2_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= pop && head.fin;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            lanes_reg <= absorbed;
        end
        if (pop && head.fin)
        begin
            s1_reg <= closed;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_reg <= s2_calc;
        end
        if (out_free && s2_valid_reg)
        begin
            digest_reg <= out_calc.a ^ out_calc.b ^ out_calc.c ^ out_calc.d;
        end
    end

    assign out_valid = out_valid_reg;
    assign digest    = digest_reg;

endmodule

[sv/siphash_2_4_stream.sv]
`timescale 1ns / 1ps
// Channel  | Handshake              | Payload
// ---------+------------------------+--------------------------------------
// config   | cfg_valid / cfg_ready  | cfg_index (0 key_low, 1 key_high), cfg_data
// input    | in_valid / in_ready    | message_word, byte_count, last
// output   | out_valid / out_ready  | digest
//
// One word per cycle unless stalled: the back end absorbs a queued block (two rounds)
// per cycle. A last item of 8 or more bytes is pushed as the word, then the length block.
// Leaving the queue, a closing block passes the s1, s2 and output registers to the digest
// (two 2-round stages); an accepted item is written into the queue before that.
// Reset clears keys, message state, queue and pipe valids; no clearing pass.
// A stalled output backs up the finalization pipe, then the queue, then in_ready.

module siphash_2_4_stream
    import sh24_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [63:0]            message_word,
    input  logic [3:0]             byte_count,
    input  logic                   last,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [63:0]            digest
);

`include "assert_macros.svh"

    logic          push;
    op_t           push_op;
    logic          pop;
    op_t           head;
    logic          q_empty;
    logic          q_full;
    front_status_t front_status;

    sh24_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .message_word (message_word),
        .byte_count   (byte_count),
        .last         (last),
        .push         (push),
        .push_op      (push_op),
        .q_full       (q_full),
        .status       (front_status)
    );

    sh24_queue #(
        .DEPTH (QDEPTH)
    ) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head    (head),
        .empty   (q_empty),
        .full    (q_full)
    );

    sh24_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .digest    (digest)
    );

    `ASSERT_SAME(a_no_push_full, push, !q_full, "push into full queue")
    `ASSERT_SAME(a_no_pop_empty, pop, !q_empty, "pop from empty queue")
    `ASSERT_NEXT(a_full_last_pends, in_valid && in_ready && last && (byte_count >= 4'd8),
                 front_status.pend, "length block not scheduled after full last word")
    `ASSERT_NEXT(a_pend_drains, front_status.pend && !q_full, !front_status.pend,
                 "pending length block not drained")

endmodule

[sim/siphash_2_4_stream_tb.sv]
`timescale 1ns / 1ps

module siphash_2_4_stream_tb;
    import sh24_pkg::*;

    localparam int PLAN_LEN = 24;
    localparam int RANDOM_ITEMS = 1000;
    localparam int SETTLE = 16;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER = 60;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [63:0] ONES = {64{1'b1}};

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } mix_state_t;

    typedef struct packed {
        logic                   is_key;
        logic [CFG_INDEX_W-1:0] reg_sel;
        logic [63:0]            data;
        logic [3:0]             cnt;
        logic                   lst;
        logic                   known;
        logic [63:0]            known_digest;
    } plan_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [63:0]            cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [63:0]            message_word = '0;
    logic [3:0]             byte_count = '0;
    logic                   last = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [63:0]            digest;

    // predictor state
    mix_state_t  hs;
    logic [7:0]  msg_len;
    bit          msg_open;
    logic [63:0] key_lo;
    logic [63:0] key_hi;

    logic [63:0] pending_digests[$];
    bit          steady = 1'b0;
    int          err_count = 0;
    int          items_sent = 0;
    int          digests_seen = 0;
    int          key_writes = 0;

    // directed rows: empty message under a zero key, the published key 00..0f vectors,
    // byte_count extremes, saturation, junk above the valid bytes, key change mid-message
    plan_row_t plan [PLAN_LEN] = '{
        '{1'b0, CFG_KEY_LOW,  ONES,                  4'd0,  1'b1, 1'b0, 64'h0},
        '{1'b1, CFG_KEY_LOW,  64'h0706050403020100,  4'd0,  1'b0, 1'b0, 64'h0},
        '{1'b1, CFG_KEY_HIGH, 64'h0f0e0d0c0b0a0908,  4'd0,  1'b0, 1'b0, 64'h0},
        '{1'b0, CFG_KEY_LOW,  ONES,                  4'd0,  1'b1, 1'b1, 64'h726fdb47dd0e0e31},
        '{1'b0, CFG_KEY_LOW,  64'h0706050403020100,  4'd0,  1'b0, 1'b0, 64'h0},
        '{1'b0, CFG_KEY_LOW,  64'hff0e0d0c0b0a0908,  4'd7,  1'b1, 1'b1, 64'ha129ca6149be45e5},
        '{1'b0, CFG_KEY_LOW,  64'h0,                 4'd8,  1'b1, 1'b0, 64'h0},
        '{1'b0, CFG_KEY_LOW,  ONES,                  4'd15, 1'b1, 1'b0, 64'h0},
        '{1'b0, CFG_KEY_LOW,  64'h0123456789abcdef,  4'd9,  1'b1, 1'b0, 64'h0},
        '{1'b0, CFG_KEY_LOW,  ONES,                  4'd1,  1'b1, 1'b0, 64'h0},
        '{1'b0, CFG_KEY_LOW,  ONES,                  4'd8,  1'b0, 1'b0, 64'h0},
        '{1'b0, CFG_KEY_LOW,  64'h0,                 4'd15, 1'b0, 1'b0, 64'h0},
        '{1'b0, CFG_KEY_LOW,  64'h8000000000000001,  4'd4,  1'b1, 1'b0, 64'h0},
        '{1'b0, CFG_KEY_LOW,  64'hdeadbeefcafef00d,  4'd3,  1'b0, 1'b0, 64'h0},
        '{1'b1, CFG_KEY_LOW,  ONES,                  4'd0,  1'b0, 1'b0, 64'h0},
        '{1'b1, CFG_KEY_HIGH, ONES,                  4'd0,  1'b0, 1'b0, 64'h0},
        '{1'b0, CFG_KEY_LOW,  64'h0011223344556677,  4'd6,  1'b1, 1'b0, 64'h0},
        '{1'b0, CFG_KEY_LOW,  64'h0,                 4'd0,  1'b1, 1'b0, 64'h0},
        '{1'b0, CFG_KEY_LOW,  ONES,                  4'd5,  1'b1, 1'b0, 64'h0},
        '{1'b1, CFG_KEY_LOW,  64'h0,                 4'd0,  1'b0, 1'b0, 64'h0},
        '{1'b1, CFG_SPARE,    ONES,                  4'd0,  1'b0, 1'b0, 64'h0},
        '{1'b0, CFG_KEY_LOW,  64'h5a5a5a5a5a5a5a5a,  4'd2,  1'b1, 1'b0, 64'h0},
        '{1'b0, CFG_KEY_LOW,  64'ha5a5a5a5a5a5a5a5,  4'd8,  1'b0, 1'b0, 64'h0},
        '{1'b0, CFG_KEY_LOW,  ONES,                  4'd7,  1'b1, 1'b0, 64'h0}
    };

    siphash_2_4_stream dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .message_word (message_word),
        .byte_count   (byte_count),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .digest       (digest)
    );

    always #1 clk = ~clk;

    function automatic logic [63:0] rol64(logic [63:0] x, int n);
        logic [127:0] t;
        t = {x, x} << n;
        return t[127:64];
    endfunction

    function automatic mix_state_t sip_mix(mix_state_t s);
        mix_state_t r;
        r = s;
        r.a = r.a + r.b; r.b = rol64(r.b, 13) ^ r.a; r.a = rol64(r.a, 32);
        r.c = r.c + r.d; r.d = rol64(r.d, 16) ^ r.c;
        r.a = r.a + r.d; r.d = rol64(r.d, 21) ^ r.a;
        r.c = r.c + r.b; r.b = rol64(r.b, 17) ^ r.c; r.c = rol64(r.c, 32);
        return r;
    endfunction

    function automatic void absorb_block(logic [63:0] m);
        hs.d = hs.d ^ m;
        hs = sip_mix(sip_mix(hs));
        hs.a = hs.a ^ m;
    endfunction

    // advance the hash by one accepted item; returns 1 when the item closes a message
    function automatic bit predict_digest(input logic [63:0] w, input logic [3:0] cnt,
                                          input bit lst, output logic [63:0] dg);
        logic [3:0]  n;
        logic [63:0] blk;
        dg = '0;
        if (!msg_open)
        begin
            hs = '{a: SIP_C0 ^ key_lo, b: SIP_C1 ^ key_hi,
                   c: SIP_C2 ^ key_lo, d: SIP_C3 ^ key_hi};
            msg_len = '0;
            msg_open = 1'b1;
        end
        if (!lst)
        begin
            absorb_block(w);
            msg_len = msg_len + 8'd8;
            return 1'b0;
        end
        n = (cnt > 4'd8) ? 4'd8 : cnt;
        if (n == 4'd8)
        begin
            absorb_block(w);
            msg_len = msg_len + 8'd8;
            blk = '0;
        end
        else
        begin
            msg_len = msg_len + 8'(n);
            blk = w & ~(ONES << (8 * n));
        end
        blk[63:56] = msg_len;
        absorb_block(blk);
        hs.c = hs.c ^ FINAL_XOR;
        repeat (4) hs = sip_mix(hs);
        dg = hs.a ^ hs.b ^ hs.c ^ hs.d;
        msg_open = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [63:0] pick_word();
        case ($urandom_range(9))
            0: return '0;
            1: return ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic offer_word(input logic [63:0] w, input logic [3:0] cnt, input bit lst,
                              input bit known, input logic [63:0] known_dg);
        logic [63:0] dg;
        while (!steady && $urandom_range(99) < 14)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        message_word <= w;
        byte_count   <= cnt;
        last         <= lst;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (predict_digest(w, cnt, lst, dg))
            pending_digests = {pending_digests, (known ? known_dg : dg)};
        items_sent++;
        @(negedge clk);
    endtask

    // write only once the block has drained
    task automatic write_key(input logic [CFG_INDEX_W-1:0] sel, input logic [63:0] val);
        in_valid <= 1'b0;
        while (pending_digests.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (sel)
            CFG_KEY_LOW:  key_lo = val;
            CFG_KEY_HIGH: key_hi = val;
            default: ;
        endcase
        key_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_message();
        int          n_words;
        logic [3:0]  cnt;
        if ($urandom_range(99) < 5)
            n_words = $urandom_range(40, 33);   // long enough to wrap the length byte
        else
            n_words = $urandom_range(4, 0);
        for (int k = 0; k < n_words; k++)
        begin
            offer_word(pick_word(), 4'($urandom_range(15)), 1'b0, 1'b0, '0);
            if (k == 0 && $urandom_range(99) < 4)
                write_key($urandom_range(1) ? CFG_KEY_HIGH : CFG_KEY_LOW, pick_word());
        end
        cnt = ($urandom_range(99) < 80) ? 4'($urandom_range(8)) : 4'($urandom_range(15, 9));
        offer_word(pick_word(), cnt, 1'b1, 1'b0, '0);
    endtask

    initial
    begin
        int rand_start;
        int next_rekey;
        key_lo = '0;
        key_hi = '0;
        hs = '0;
        msg_len = '0;
        msg_open = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if (plan[i].is_key)
                write_key(plan[i].reg_sel, plan[i].data);
            else
                offer_word(plan[i].data, plan[i].cnt, plan[i].lst, plan[i].known,
                           plan[i].known_digest);
        end

        rand_start = items_sent;
        next_rekey = 0;
        while (items_sent - rand_start < RANDOM_ITEMS)
        begin
            steady = (items_sent - rand_start >= 400) && (items_sent - rand_start < 600);
            if (items_sent - rand_start >= next_rekey)
            begin
                write_key(CFG_KEY_LOW, pick_word());
                if ($urandom_range(3) != 0)
                    write_key(CFG_KEY_HIGH, pick_word());
                next_rekey = next_rekey + 150;
            end
            send_message();
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        while (pending_digests.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        $display("Sent %0d items (%0d directed), checked %0d digests, %0d key writes.",
                 items_sent, rand_start, digests_seen, key_writes);
        $display("Covered short, saturated and wrapped-length messages and a long output stall.");
        if (err_count == 0)
            $display("siphash_2_4_stream test passed");
        else
            $display("siphash_2_4_stream test failed");
        $finish;
    end

    // receiver: random stalls plus one long hold-off to back the block up
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && digests_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready <= steady || ($urandom_range(99) >= 14);
        end
    end

    always @(posedge clk)
    begin
        logic [63:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            digests_seen++;
            if (pending_digests.size() == 0)
            begin
                $error("digest: unexpected item, actual %h", digest);
                err_count++;
            end
            else
            begin
                want = pending_digests.pop_front();
                if (digest !== want)
                begin
                    $error("digest: expected %h, actual %h", want, digest);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        #400000;
        $display("Timeout with %0d digests outstanding.", pending_digests.size());
        $display("siphash_2_4_stream test failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/sh24_pkg.sv
sv/sh24_front.sv
sv/sh24_queue.sv
sv/sh24_back.sv
sv/siphash_2_4_stream.sv
sim/siphash_2_4_stream_tb.sv
